FILE: sv/vertex_transform_4x4_macros.svh
// Assertion macros for the vertex transform checker
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH
// implication checked every clock, off in reset
`define VT_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// implication checked in the following cycle
`define VT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

FILE: sv/vt4_pkg.sv
// Package: types, constants and register indexes for the vertex transform
package vt4_pkg;
   localparam int NUM_REGS = 8;
   localparam int REG_IDX_W = 3;
   localparam int CSR_IDX_W = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [31:0] ONE_Q = 32'h0001_0000;
   localparam int DIV_STAGES = 48;

   typedef enum logic [1:0] {
      ACT_HOMOG = 2'd0,
      ACT_DIR   = 2'd1,
      ACT_POINT = 2'd2,
      ACT_SPARE = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               saturated;
      logic               divide_by_zero;
   } rsp_type;

   // classified item as queued between front and back
   typedef struct packed {
      logic               dir;    // direction: 3x3, w forced 0
      logic               point;  // divide by w
      logic signed [31:0] v0;
      logic signed [31:0] v1;
      logic signed [31:0] v2;
      logic signed [31:0] v3;
   } item_type;

   localparam logic [63:0] REG_RESET [NUM_REGS] = '{
      64'd65536, 64'd0, 64'd281474976710656, 64'd0,
      64'd0, 64'd65536, 64'd0, 64'd281474976710656
   };
endpackage

FILE: sv/vt4_front.sv
// Front end: accepts requests, classifies the action, fills the item queue
module vt4_front #(
   parameter int DEPTH = vt4_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  vt4_pkg::req_type   req_data,
   output logic               item_valid,
   input  logic               item_take,
   output vt4_pkg::item_type  item
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   vt4_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic push, pop;
   vt4_pkg::item_type cls;

   always_comb begin
      cls.dir   = (req_data.action == vt4_pkg::ACT_DIR);
      cls.point = (req_data.action == vt4_pkg::ACT_POINT);
      cls.v0 = req_data.in_x;
      cls.v1 = req_data.in_y;
      cls.v2 = cls.dir ? 32'sd0 : req_data.in_z;
      cls.v3 = cls.point ? $signed(vt4_pkg::ONE_Q)
             : (cls.dir ? 32'sd0 : req_data.in_w);
      if (cls.dir) cls.v2 = req_data.in_z;
   end

   assign busy = (cnt_ff == (PW+1)'(DEPTH)) && !item_take;
   assign push = start && !busy;
   assign pop  = item_valid && item_take;
   assign item_valid = (cnt_ff != '0);
   assign item = mem_ff[rd_ff];

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in = push ? nxt(wr_ff) : wr_ff;
      rd_in = pop ? nxt(rd_ff) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= cls;
   end
endmodule

FILE: sv/vt4_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding
module vt4_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [47:0] num,      // |c| * 2^16
   input  logic [31:0] den,      // |w|, nonzero
   input  logic        neg,
   output logic        out_valid,
   output logic signed [31:0] quot,
   output logic        sat
);
   localparam int N = vt4_pkg::DIV_STAGES;
   logic        v_ff   [N+1];
   logic [47:0] q_ff   [N+1];
   logic [32:0] r_ff   [N+1];
   logic [31:0] d_ff   [N+1];
   logic        n_ff   [N+1];

   always_comb begin
      v_ff[0] = in_valid; q_ff[0] = num; r_ff[0] = '0;
      d_ff[0] = den; n_ff[0] = neg;
   end

   for (genvar s = 0; s < N; s++) begin : g_st
      logic [32:0] t;
      logic        ge;
      assign t  = {r_ff[s][31:0], q_ff[s][47]};
      assign ge = (t >= {1'b0, d_ff[s]});
      always_ff @(posedge clock) begin
         if (reset) v_ff[s+1] <= 1'b0;
         else       v_ff[s+1] <= v_ff[s];
         q_ff[s+1] <= {q_ff[s][46:0], ge};
         r_ff[s+1] <= ge ? t - {1'b0, d_ff[s]} : t;
         d_ff[s+1] <= d_ff[s];
         n_ff[s+1] <= n_ff[s];
      end
   end

   // round half away: bump when 2*rem >= den
   logic [48:0] qr;
   logic [49:0] sq;
   assign qr = {1'b0, q_ff[N]} +
               49'(({r_ff[N], 1'b0} >= {2'b0, d_ff[N]}) ? 1 : 0);
   assign sq = n_ff[N] ? -{1'b0, qr} : {1'b0, qr};
   always_comb begin
      out_valid = v_ff[N];
      sat = 1'b0;
      quot = sq[31:0];
      if ($signed(sq) > 50'sh7FFF_FFFF) begin
         sat = 1'b1; quot = 32'sh7FFF_FFFF;
      end else if ($signed(sq) < -50'sh8000_0000) begin
         sat = 1'b1; quot = 32'sh8000_0000;
      end
   end
endmodule

FILE: sv/vt4_back.sv
// Back end: matrix product pipeline, optional divide by w, result strobe
module vt4_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_take,
   input  vt4_pkg::item_type  item,
   input  logic [63:0]        mat [vt4_pkg::NUM_REGS],
   output logic               rsp_valid,
   output vt4_pkg::rsp_type   rsp_data
);
   localparam int DS = vt4_pkg::DIV_STAGES;
   // back never stalls: fixed-latency pipe
   assign item_take = item_valid;

   function automatic logic signed [31:0] cf(input logic [63:0] m [vt4_pkg::NUM_REGS],
                                             input int r, input int c);
      logic [63:0] rg;
      rg = m[2*r + c/2];
      return (c % 2 == 1) ? rg[63:32] : rg[31:0];
   endfunction

   // stage 1: 16 products
   logic s1_v_ff, s1_d_ff, s1_p_ff;
   logic signed [63:0] p_ff [4][4];
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0; else s1_v_ff <= item_take;
      s1_d_ff <= item.dir; s1_p_ff <= item.point;
      for (int c = 0; c < 4; c++) begin
         p_ff[0][c] <= item.v0 * cf(mat, 0, c);
         p_ff[1][c] <= item.v1 * cf(mat, 1, c);
         p_ff[2][c] <= (item.v2 * cf(mat, 2, c));
         p_ff[3][c] <= item.dir ? 64'sd0 : item.v3 * cf(mat, 3, c);
      end
   end

   // stage 2: sum, round, saturate
   logic s2_v_ff, s2_d_ff, s2_p_ff;
   logic signed [31:0] c_ff [4];
   logic [3:0] cs_ff;
   always_ff @(posedge clock) begin
      logic signed [66:0] sum, rs;
      logic signed [31:0] cv;
      logic [3:0] cs;
      if (reset) s2_v_ff <= 1'b0; else s2_v_ff <= s1_v_ff;
      s2_d_ff <= s1_d_ff; s2_p_ff <= s1_p_ff;
      cs = '0;
      for (int c = 0; c < 4; c++) begin
         sum = 67'(p_ff[0][c]) + 67'(p_ff[1][c]) + 67'(p_ff[2][c])
             + 67'(p_ff[3][c]) + 67'sd32768;
         rs = sum >>> 16;
         if (rs > 67'sh7FFF_FFFF) begin
            cv = 32'sh7FFF_FFFF; cs[c] = 1'b1;
         end else if (rs < -67'sh8000_0000) begin
            cv = 32'sh8000_0000; cs[c] = 1'b1;
         end else begin
            cv = rs[31:0]; cs[c] = 1'b0;
         end
         if (c == 3 && s1_d_ff) begin
            cv = '0; cs[c] = 1'b0;
         end
         c_ff[c] <= cv;
      end
      cs_ff <= cs;
   end

   // divider lanes for x, y, z
   logic [2:0] dq_v, dq_s;
   logic signed [31:0] dq [3];
   logic [31:0] aw;
   assign aw = c_ff[3][31] ? 32'(-c_ff[3]) : c_ff[3];
   for (genvar l = 0; l < 3; l++) begin : g_div
      logic [31:0] ac;
      assign ac = c_ff[l][31] ? 32'(-c_ff[l]) : c_ff[l];
      vt4_divider u_div (
         .clock(clock), .reset(reset), .in_valid(s2_v_ff),
         .num({ac, 16'h0}), .den((aw == '0) ? 32'd1 : aw),
         .neg(c_ff[l][31] != c_ff[3][31]),
         .out_valid(dq_v[l]), .quot(dq[l]), .sat(dq_s[l])
      );
   end

   // delay line for the non-divide result alongside divider
   vt4_pkg::rsp_type dl_ff [DS+1];
   logic dp_ff [DS+1], dz_ff [DS+1];
   always_comb begin
      dl_ff[0].out_x = c_ff[0]; dl_ff[0].out_y = c_ff[1];
      dl_ff[0].out_z = c_ff[2]; dl_ff[0].out_w = c_ff[3];
      dl_ff[0].saturated = s2_d_ff ? |cs_ff[2:0] : |cs_ff;
      dl_ff[0].divide_by_zero = 1'b0;
      dp_ff[0] = s2_p_ff; dz_ff[0] = (c_ff[3] == '0);
   end
   for (genvar s = 0; s < DS; s++) begin : g_dl
      always_ff @(posedge clock) begin
         dl_ff[s+1] <= dl_ff[s]; dp_ff[s+1] <= dp_ff[s]; dz_ff[s+1] <= dz_ff[s];
      end
   end

   logic rv_ff;
   vt4_pkg::rsp_type r_ff, r_in;
   always_comb begin
      r_in = dl_ff[DS];
      if (dp_ff[DS]) begin
         if (dz_ff[DS]) begin
            r_in = '0;
            r_in.divide_by_zero = 1'b1;
         end else begin
            r_in.out_x = dq[0]; r_in.out_y = dq[1]; r_in.out_z = dq[2];
            r_in.out_w = $signed(vt4_pkg::ONE_Q);
            r_in.saturated = dl_ff[DS].saturated | (|dq_s);
            r_in.divide_by_zero = 1'b0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0; else rv_ff <= &dq_v;
      r_ff <= r_in;
   end
   assign rsp_valid = rv_ff;
   assign rsp_data = r_ff;
endmodule

FILE: sv/vertex_transform_4x4.sv
// Top level of the vertex transform
// One vertex is taken per cycle (start high, busy low) and its result shows on
// rsp_valid for one cycle: the item waits in the queue, then one multiply
// stage, one sum/round stage, a 48-stage pipelined divider that sets the
// latency for every action, and the output register. A four-entry queue
// separates the request side from the arithmetic pipe; the pipe never
// stalls and the receiver cannot hold results off, so busy stays low in
// steady use and results leave one per cycle. The user must write matrix
// registers through csr_ only while the block is idle; nothing enforces it.
module vertex_transform_4x4 #(
   parameter int QUEUE_DEPTH = vt4_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vt4_pkg::req_type req_data,
   output logic             rsp_valid,
   output vt4_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [vt4_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]      csr_data
);
   logic [63:0] mat_ff [vt4_pkg::NUM_REGS];
   logic iv, it;
   vt4_pkg::item_type itm;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vt4_pkg::NUM_REGS; i++) mat_ff[i] <= vt4_pkg::REG_RESET[i];
      end else if (csr_valid && csr_index < vt4_pkg::CSR_IDX_W'(vt4_pkg::NUM_REGS)) begin
         mat_ff[csr_index[vt4_pkg::REG_IDX_W-1:0]] <= csr_data;
      end
   end

   vt4_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .item_valid(iv), .item_take(it), .item(itm)
   );
   vt4_back u_back (
      .clock(clock), .reset(reset), .item_valid(iv), .item_take(it),
      .item(itm), .mat(mat_ff), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule

FILE: sv/vt4_checker.sv
// Port-level assertion checker for the vertex transform, with its bind
`include "vertex_transform_4x4_macros.svh"
module vt4_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input vt4_pkg::rsp_type rsp_data
);
   `VT_ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid && rsp_data.divide_by_zero, rsp_data.out_x == 32'sd0 && rsp_data.out_w == 32'sd0 && !rsp_data.saturated)
   `VT_ASSERT_NEXT(a_no_busy_idle, clock, reset, !start, !busy)
   `VT_ASSERT_IMP(a_rsp_after_reset, clock, reset, $fell(reset), !rsp_valid)
endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

FILE: tb/sv/vertex_transform_4x4_test.sv
// Testbench for the 4x4 vertex transform: directed and random vertices checked against a fixed-point predictor
module vertex_transform_4x4_test;

   // matrix copy used by the predictor
   logic [63:0] mat [vt4_pkg::NUM_REGS];

   function automatic longint coef_of(int r, int c);
      logic [63:0] rv;
      logic signed [31:0] h;
      rv = mat[r * 2 + c / 2];
      h = (c % 2) ? rv[63:32] : rv[31:0];
      return longint'(h);
   endfunction

   // exact sum of products, rounded half up to Q16.16 (floor of sum + 2^15)
   function automatic longint dot_col(longint v [4], int col, int n);
      logic signed [95:0] acc;
      acc = 0;
      for (int k = 0; k < n; k++) acc += 96'(v[k]) * 96'(coef_of(k, col));
      acc = acc + 96'sd32768;
      return longint'(acc >>> 16);
   endfunction

   function automatic longint clamp(longint x, ref bit f);
      if (x > 64'sd2147483647) begin
         f = 1; return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         f = 1; return -64'sd2147483648;
      end
      return x;
   endfunction

   function automatic longint qdiv(longint c, longint w);
      longint n, an, ad, q;
      n = c * 65536;
      an = n < 0 ? -n : n;
      ad = w < 0 ? -w : w;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (w < 0)) ? -q : q;
   endfunction

   function automatic vt4_pkg::rsp_type transform_vertex(vt4_pkg::req_type q);
      longint v [4];
      longint r [4];
      bit sat, dz;
      vt4_pkg::rsp_type o;
      sat = 0; dz = 0;
      v[0] = q.in_x; v[1] = q.in_y; v[2] = q.in_z; v[3] = q.in_w;
      r = '{0, 0, 0, 0};
      if (q.action == vt4_pkg::ACT_DIR) begin
         for (int c = 0; c < 3; c++) r[c] = clamp(dot_col(v, c, 3), sat);
      end else if (q.action == vt4_pkg::ACT_POINT) begin
         v[3] = 65536;
         for (int c = 0; c < 4; c++) r[c] = clamp(dot_col(v, c, 4), sat);
         if (r[3] == 0) begin
            dz = 1; sat = 0; r[0] = 0; r[1] = 0; r[2] = 0;
         end else begin
            for (int c = 0; c < 3; c++) r[c] = clamp(qdiv(r[c], r[3]), sat);
            r[3] = 65536;
         end
      end else begin
         for (int c = 0; c < 4; c++) r[c] = clamp(dot_col(v, c, 4), sat);
      end
      o.out_x = r[0][31:0]; o.out_y = r[1][31:0];
      o.out_z = r[2][31:0]; o.out_w = r[3][31:0];
      o.saturated = sat; o.divide_by_zero = dz;
      return o;
   endfunction

   class vertex_scoreboard;
      vt4_pkg::rsp_type pending [$];
      int errors;
      function void note_vertex(vt4_pkg::req_type q);
         pending.push_back(transform_vertex(q));
      endfunction
      function void check_vertex(vt4_pkg::rsp_type got);
         vt4_pkg::rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, csr_valid = 0;
   logic busy, rsp_valid, csr_ready;
   vt4_pkg::req_type req_data = '0;
   vt4_pkg::rsp_type rsp_data;
   logic [vt4_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;
   vertex_scoreboard board = new();
   int cycles = 0;
   localparam int LIMIT = 400000;

   vertex_transform_4x4 DUT (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && start && !busy) board.note_vertex(req_data);
      if (!reset && rsp_valid) board.check_vertex(rsp_data);
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(int idx, logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= vt4_pkg::CSR_IDX_W'(idx); csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < vt4_pkg::NUM_REGS) mat[idx] = val;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic wait_drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      @(negedge clock);
   endtask

   // one vertex transfer, starting and ending at a falling edge
   task automatic send_vertex(vt4_pkg::req_type q);
      start <= 1; req_data <= q;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_comp(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 65536 * 8) - 65536 * 4;
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic vt4_pkg::req_type rand_vertex();
      vt4_pkg::req_type q;
      int m;
      m = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
      q.action = ($urandom_range(0, 9) == 0) ? 2'(vt4_pkg::ACT_SPARE)
                                              : 2'($urandom_range(0, 2));
      q.in_x = rand_comp(m); q.in_y = rand_comp(m);
      q.in_z = rand_comp(m); q.in_w = rand_comp(m);
      return q;
   endfunction

   function automatic logic [63:0] rand_reg(int r, int setting);
      logic [31:0] a, b;
      case (setting)
         0: return {rand_comp(1), rand_comp(1)};
         1: return {$urandom(), $urandom()};
         2: return $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
         default: begin
            a = (r % 2 == 0) ? 32'($urandom_range(0, 65536 * 3)) : rand_comp(2);
            b = rand_comp(2);
            return {b, a};
         end
      endcase
   endfunction

   initial begin
      vt4_pkg::req_type q;
      int burst;
      int gap;
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) mat[i] = vt4_pkg::REG_RESET[i];
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: identity matrix, extreme fields, every action
      for (int a = 0; a < 4; a++) begin
         q.action = 2'(a);
         q.in_x = 32'h7FFF_FFFF; q.in_y = 32'h8000_0000;
         q.in_z = 32'h0001_8000; q.in_w = 32'hFFFF_FFFF;
         send_vertex(q);
         q.in_x = 0; q.in_y = 0; q.in_z = 0; q.in_w = 0;
         send_vertex(q);
      end
      start <= 0;
      wait_drain();
      // perspective matrix: w = z, so z = -1.0 divides, z = 0 hits divide by zero
      write_reg(7, {32'h0000_0000, 32'h0000_0000});
      write_reg(5, {32'h0001_0000, 32'h0001_0000});
      write_reg(9, 64'hDEAD_BEEF);
      for (int k = 0; k < 6; k++) begin
         q.action = vt4_pkg::ACT_POINT;
         q.in_x = k * 32'h0003_0000; q.in_y = -k * 32'h0000_8000;
         q.in_z = (k == 0) ? 0 : (k == 1) ? 32'hFFFF_0000 : (k == 2) ? 32'h0000_0001 : k << 12;
         q.in_w = $urandom();
         send_vertex(q);
      end
      start <= 0;
      wait_drain();

      for (int phase = 0; phase < 9; phase++) begin
         for (int r = 0; r < vt4_pkg::NUM_REGS; r++) write_reg(r, rand_reg(r, phase % 4));
         for (int n = 0; n < 150;) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < 150; b++, n++) send_vertex(rand_vertex());
            if ($urandom_range(0, 9) == 0) begin
               start <= 0;
               wait_drain();
            end else begin
               gap = $urandom_range(0, 6);
               if (gap != 0) begin
                  start <= 0;
                  repeat (gap) @(negedge clock);
               end
            end
         end
         start <= 0;
         wait_drain();
      end

      if (board.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+sv
sv/vt4_pkg.sv
sv/vt4_front.sv
sv/vt4_divider.sv
sv/vt4_back.sv
sv/vertex_transform_4x4.sv
sv/vt4_checker.sv
tb/sv/vertex_transform_4x4_test.sv
